FILE: rtl/scpp_pkg.sv
// Shared types and constants of the serial command packet parser.
package scpp_pkg;

    // Event codes carried on the result stream.
    localparam logic [2:0] EV_BAD        = 3'd0;
    localparam logic [2:0] EV_LOOP       = 3'd1;
    localparam logic [2:0] EV_ADC        = 3'd2;
    localparam logic [2:0] EV_LED_ON     = 3'd3;
    localparam logic [2:0] EV_LED_OFF    = 3'd4;
    localparam logic [2:0] EV_LED_TOGGLE = 3'd5;

    // Frame bytes.
    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [7:0] PARAM_ON   = 8'h4C;  // 'L'
    localparam logic [7:0] PARAM_OFF  = 8'h44;  // 'D'
    localparam logic [7:0] PARAM_TGL  = 8'h54;  // 'T'

    // Register map: register index taken from paddr[3:2].
    localparam logic [1:0] REG_LED_CODE  = 2'd0;
    localparam logic [1:0] REG_LOOP_CODE = 2'd1;
    localparam logic [1:0] REG_ADC_CODE  = 2'd2;

    localparam logic [7:0] LED_CODE_RST  = 8'd16;
    localparam logic [7:0] LOOP_CODE_RST = 8'd17;
    localparam logic [7:0] ADC_CODE_RST  = 8'd18;

    // Command byte values that select each command.
    typedef struct packed {
        logic [7:0] led;
        logic [7:0] loopback;
        logic [7:0] adc;
    } cmd_codes_t;

    // Outcome of parsing one byte.
    typedef struct packed {
        logic       emit;
        logic [2:0] event_code;
    } parse_result_t;

endpackage

FILE: rtl/scpp_fsm.sv
// Frame parser state machine: checks one byte per cycle, while advance is high, against the frame format.
module scpp_fsm
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic [7:0]              rx_byte,
    input  scpp_pkg::cmd_codes_t    codes,
    output scpp_pkg::parse_result_t result
);

    typedef enum logic [2:0] {
        PH_START,
        PH_CMD,
        PH_LEN,
        PH_PARAM,
        PH_CHECK
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LED,
        KIND_LOOP,
        KIND_ADC
    } kind_t;

    phase_t     phase_reg, phase_next;
    kind_t      kind_reg, kind_next;
    logic [2:0] pending_reg, pending_next;
    logic [7:0] sum_reg, sum_next;
    logic       emit;
    logic [2:0] event_code;

    always_comb
    begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        pending_next = pending_reg;
        sum_next     = sum_reg + rx_byte;
        emit         = 1'b0;
        event_code   = scpp_pkg::EV_BAD;

        case (phase_reg)
            PH_CMD:
            begin
                phase_next = PH_LEN;
                if (rx_byte == codes.led)
                begin
                    kind_next = KIND_LED;
                end
                else if (rx_byte == codes.loopback)
                begin
                    kind_next    = KIND_LOOP;
                    pending_next = scpp_pkg::EV_LOOP;
                end
                else if (rx_byte == codes.adc)
                begin
                    kind_next    = KIND_ADC;
                    pending_next = scpp_pkg::EV_ADC;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            PH_LEN:
            begin
                if (rx_byte == 8'd1 && kind_reg == KIND_LED)
                begin
                    phase_next = PH_PARAM;
                end
                else if (rx_byte == 8'd0 && (kind_reg == KIND_LOOP || kind_reg == KIND_ADC))
                begin
                    phase_next = PH_CHECK;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            PH_PARAM:
            begin
                phase_next = PH_CHECK;
                if (rx_byte == scpp_pkg::PARAM_ON)
                begin
                    pending_next = scpp_pkg::EV_LED_ON;
                end
                else if (rx_byte == scpp_pkg::PARAM_OFF)
                begin
                    pending_next = scpp_pkg::EV_LED_OFF;
                end
                else if (rx_byte == scpp_pkg::PARAM_TGL)
                begin
                    pending_next = scpp_pkg::EV_LED_TOGGLE;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            PH_CHECK:
            begin
                // The checksum byte always closes the frame.
                emit = 1'b1;
                if (rx_byte == sum_reg)
                begin
                    event_code = pending_reg;
                end
            end
            default:
            begin
                if (rx_byte == scpp_pkg::START_BYTE)
                begin
                    phase_next   = PH_CMD;
                    kind_next    = KIND_NONE;
                    pending_next = scpp_pkg::EV_BAD;
                    sum_next     = rx_byte;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
        endcase

        // Every emitted event returns the parser to its idle state.
        if (emit)
        begin
            phase_next   = PH_START;
            kind_next    = KIND_NONE;
            pending_next = scpp_pkg::EV_BAD;
            sum_next     = 8'd0;
        end
    end

    assign result.emit       = emit;
    assign result.event_code = event_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            kind_reg    <= KIND_NONE;
            pending_reg <= scpp_pkg::EV_BAD;
            sum_reg     <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
            pending_reg <= pending_next;
            sum_reg     <= sum_next;
        end
    end

endmodule

FILE: rtl/serial_command_packet_parser_core.sv
// Top level of the serial command packet parser: stream ports, register port and staging.
//
// The block takes received serial bytes on the s_* stream, one byte per beat,
// and parses frames of the form start (0x01), command, length, optional
// parameter byte, checksum. The checksum is the low byte of the sum of all
// earlier frame bytes. Every completed frame gives one beat on the m_* stream
// carrying its event code; any wrong byte gives a bad-packet event (code 0)
// and the parser waits for a new start byte. Bytes inside a good frame give
// no output beat.
// Throughput is one byte per clock cycle unless an event waits on a stalled
// receiver: a byte is captured in the input register, then checked against
// the parser state, which writes any event into the output register that
// drives m_tvalid.
// When the receiver stalls with an event waiting, a byte that would produce
// another event holds in the input register and s_tready falls; bytes that
// produce no event keep flowing through.
// The APB port holds the three command codes (LED at 0x0, loopback at 0x4,
// ADC at 0x8); change them only while no frame is in progress.
// Reset clears the parser to wait for a start byte, empties both stages and
// loads the command codes 16, 17 and 18.
module serial_command_packet_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [2:0] event_code, [7:3] zero
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    scpp_pkg::cmd_codes_t    codes_reg;
    scpp_pkg::parse_result_t result;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic [2:0] out_event_reg;
    logic       out_free;
    logic       advance;
    logic       cfg_write;
    logic [1:0] reg_index;

    // Register port: zero wait states, writes on the access cycle.
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.led      <= scpp_pkg::LED_CODE_RST;
            codes_reg.loopback <= scpp_pkg::LOOP_CODE_RST;
            codes_reg.adc      <= scpp_pkg::ADC_CODE_RST;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                scpp_pkg::REG_LED_CODE:  codes_reg.led      <= pwdata[7:0];
                scpp_pkg::REG_LOOP_CODE: codes_reg.loopback <= pwdata[7:0];
                scpp_pkg::REG_ADC_CODE:  codes_reg.adc      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            scpp_pkg::REG_LED_CODE:  prdata = {24'd0, codes_reg.led};
            scpp_pkg::REG_LOOP_CODE: prdata = {24'd0, codes_reg.loopback};
            scpp_pkg::REG_ADC_CODE:  prdata = {24'd0, codes_reg.adc};
            default:                 prdata = 32'd0;
        endcase
    end

    // The staged byte is consumed when its event, if any, has room in the
    // output register. A byte without an event never waits on the receiver.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (out_free || !result.emit);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    scpp_fsm u_fsm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_byte (in_byte_reg),
        .codes   (codes_reg),
        .result  (result)
    );

    // Output register: loads a new event or drains when the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && result.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
        begin
            out_event_reg <= result.event_code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_event_reg};

    // A staged byte that is not consumed must still be there next cycle.
    a_hold_staged_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("staged byte lost while parser was stalled");

    // An accepted beat lands in the input register.
    a_capture_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> in_valid_reg && in_byte_reg == $past(s_tdata))
        else $error("accepted beat not captured");

    // An event is never written over one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !(advance && result.emit))
        else $error("pending event overwritten");

    // Only defined event codes leave the block.
    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= scpp_pkg::EV_LED_TOGGLE)
        else $error("undefined event code on output");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the serial command packet parser core.
module tb;

    // Frame walk as the checker tracks it, one step per accepted byte.
    typedef enum logic [2:0]
    {
        PH_WAIT_START,
        PH_COMMAND,
        PH_LENGTH,
        PH_PARAMETER,
        PH_CHECKSUM
    } frame_step_t;

    // Which command the current frame selected.
    typedef enum logic [1:0]
    {
        KIND_NONE,
        KIND_LED,
        KIND_LOOPBACK,
        KIND_ADC
    } cmd_kind_t;

    // Length byte values that a frame may carry.
    localparam logic [7:0] LEN_NONE  = 8'd0;
    localparam logic [7:0] LEN_PARAM = 8'd1;

    // A register slot past the last command code; writes there must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int PHASE_BYTES   = 72;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_CYCLES  = 4;
    localparam int REPORT_LINES  = 20;

    // Tracks the parser state and the queue of event codes still owed by the block.
    class frame_event_checker;
        bit [7:0]     led_code;
        bit [7:0]     loop_code;
        bit [7:0]     adc_code;
        frame_step_t  step;
        cmd_kind_t    kind;
        bit [2:0]     pending_ev;
        bit [7:0]     running_sum;
        bit [2:0]     owed_events[$];
        int           mismatches;
        int           events_seen;

        function new();
            led_code    = scpp_pkg::LED_CODE_RST;
            loop_code   = scpp_pkg::LOOP_CODE_RST;
            adc_code    = scpp_pkg::ADC_CODE_RST;
            mismatches  = 0;
            events_seen = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            step        = PH_WAIT_START;
            kind        = KIND_NONE;
            pending_ev  = scpp_pkg::EV_BAD;
            running_sum = 8'd0;
        endfunction

        function void set_code(bit [1:0] idx, bit [7:0] value);
            case (idx)
                scpp_pkg::REG_LED_CODE:  led_code  = value;
                scpp_pkg::REG_LOOP_CODE: loop_code = value;
                scpp_pkg::REG_ADC_CODE:  adc_code  = value;
                default: ;
            endcase
        endfunction

        function void absorb(bit [7:0] b, frame_step_t next_step);
            running_sum = running_sum + b;
            step        = next_step;
        endfunction

        // Notes one accepted byte and queues the event that it produces, if any.
        function void note_byte(bit [7:0] b);
            bit       emit;
            bit [2:0] ev;
            emit = 1'b0;
            ev   = scpp_pkg::EV_BAD;
            case (step)
                PH_COMMAND:
                begin
                    // The LED code wins over loopback, which wins over ADC.
                    if (b == led_code)
                        kind = KIND_LED;
                    else if (b == loop_code)
                    begin
                        kind       = KIND_LOOPBACK;
                        pending_ev = scpp_pkg::EV_LOOP;
                    end
                    else if (b == adc_code)
                    begin
                        kind       = KIND_ADC;
                        pending_ev = scpp_pkg::EV_ADC;
                    end
                    else
                        emit = 1'b1;
                    if (!emit)
                        absorb(b, PH_LENGTH);
                end
                PH_LENGTH:
                begin
                    if (b == LEN_PARAM && kind == KIND_LED)
                        absorb(b, PH_PARAMETER);
                    else if (b == LEN_NONE && (kind == KIND_LOOPBACK || kind == KIND_ADC))
                        absorb(b, PH_CHECKSUM);
                    else
                        emit = 1'b1;
                end
                PH_PARAMETER:
                begin
                    if (b == scpp_pkg::PARAM_ON)
                        pending_ev = scpp_pkg::EV_LED_ON;
                    else if (b == scpp_pkg::PARAM_OFF)
                        pending_ev = scpp_pkg::EV_LED_OFF;
                    else if (b == scpp_pkg::PARAM_TGL)
                        pending_ev = scpp_pkg::EV_LED_TOGGLE;
                    else
                        emit = 1'b1;
                    if (!emit)
                        absorb(b, PH_CHECKSUM);
                end
                PH_CHECKSUM:
                begin
                    // The checksum byte closes the frame whether it matches or not.
                    emit = 1'b1;
                    if (b == running_sum)
                        ev = pending_ev;
                end
                default:
                begin
                    if (b == scpp_pkg::START_BYTE)
                    begin
                        clear_frame();
                        absorb(b, PH_COMMAND);
                    end
                    else
                        emit = 1'b1;
                end
            endcase
            if (emit)
            begin
                owed_events.push_back(ev);
                clear_frame();
            end
        endfunction

        task report(string msg);
            if (mismatches < REPORT_LINES)
                $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        // Compares one result beat with the oldest owed event.
        task check_event(bit [7:0] beat);
            bit [2:0] want;
            events_seen++;
            if (owed_events.size() == 0)
            begin
                report($sformatf("event %0d arrived with nothing owed", beat[2:0]));
                return;
            end
            want = owed_events.pop_front();
            if (beat[2:0] != want)
                report($sformatf("event_code %0d, wanted %0d", beat[2:0], want));
            if (beat[7:3] != 5'd0)
                report($sformatf("padding bits of result beat are %b", beat[7:3]));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [2:0] event_code, [7:3] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_event_checker sb = new();

    // Shared knobs between the stimulus thread and the result-side thread.
    bit quiet;          // No random idling on either side while set.
    bit hold_request;   // Asks the result side for one long stall.
    int bytes_sent;
    int cycle_count;

    serial_command_packet_parser_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one byte, sometimes after a short gap, and returns in the time step of the
    // edge that accepted it. tvalid is left high so the next byte can follow without a
    // bubble; whoever stops sending must lower it in that same step.
    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(0, 99) < 5)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // Sends start, command, length, optional parameter and checksum. A nonzero
    // sum_error spoils the checksum byte by that amount.
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                              input logic has_param, input logic [7:0] param,
                              input logic [7:0] sum_error);
        logic [7:0] sum;
        sum = scpp_pkg::START_BYTE + cmd + len;
        send_byte(scpp_pkg::START_BYTE);
        send_byte(cmd);
        send_byte(len);
        if (has_param)
        begin
            sum = sum + param;
            send_byte(param);
        end
        send_byte(sum + sum_error);
    endtask

    // Most frames are well formed with random command and parameter; some have one
    // field spoiled, and the rest is line noise.
    task automatic random_frame();
        int         pick;
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] param;
        logic       has_param;
        logic [7:0] sum_error;
        pick      = $urandom_range(0, 99);
        sum_error = 8'd0;
        param     = 8'd0;
        if (pick < 15)
        begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 2))
            0:
            begin
                cmd       = sb.led_code;
                len       = LEN_PARAM;
                has_param = 1'b1;
                case ($urandom_range(0, 2))
                    0: param = scpp_pkg::PARAM_ON;
                    1: param = scpp_pkg::PARAM_OFF;
                    default: param = scpp_pkg::PARAM_TGL;
                endcase
            end
            1:
            begin
                cmd       = sb.loop_code;
                len       = LEN_NONE;
                has_param = 1'b0;
            end
            default:
            begin
                cmd       = sb.adc_code;
                len       = LEN_NONE;
                has_param = 1'b0;
            end
        endcase
        if (pick < 30)
        begin
            case ($urandom_range(0, 3))
                0: cmd = 8'($urandom_range(0, 255));
                1: len = 8'($urandom_range(0, 255));
                2:
                begin
                    has_param = 1'b1;
                    param     = 8'($urandom_range(0, 255));
                end
                default: sum_error = 8'($urandom_range(1, 255));
            endcase
        end
        send_frame(cmd, len, has_param, param, sum_error);
    endtask

    // Picks a byte that is certain to end whatever frame is open.
    function automatic logic [7:0] closing_byte();
        logic [7:0] b;
        b = 8'd0;
        case (sb.step)
            PH_COMMAND:
                while (b == sb.led_code || b == sb.loop_code || b == sb.adc_code)
                    b = b + 8'd1;
            PH_LENGTH:
                b = 8'd2;
            default:
                b = 8'd0;
        endcase
        return b;
    endfunction

    // Closes any open frame, lowers tvalid and waits for the block to go quiet so the
    // command codes can be changed safely.
    task automatic settle();
        while (sb.step != PH_WAIT_START)
            send_byte(closing_byte());
        s_tvalid <= 1'b0;
        while (sb.owed_events.size() != 0)
            @(posedge clk);
        // A byte that makes no event may still sit in the input stage.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, access cycle, then an idle wait with psel low so the next
    // write never touches psel twice in one time step.
    task automatic write_code(input logic [1:0] idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_code(idx, value);
        @(posedge clk);
    endtask

    // Result side: checks every accepted beat and drives tready. It idles now and
    // then, runs flat out while quiet is set, and takes one long stall on request so
    // that the block fills up and pushes back on the byte stream.
    initial
    begin
        int stall;
        stall    = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_event(m_tdata);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall        = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= quiet || ($urandom_range(0, 99) >= 10);
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d events still owed",
                 cycle_count, sb.owed_events.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int         start_count;
        logic [7:0] shared;
        quiet        = 1'b0;
        hold_request = 1'b0;
        bytes_sent   = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= 4'd0;
        pwdata   <= 32'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset command codes: the good LED and loopback commands,
        // then each way a frame can go wrong.
        send_frame(scpp_pkg::LED_CODE_RST, LEN_PARAM, 1'b1, scpp_pkg::PARAM_ON, 8'd0);
        send_frame(scpp_pkg::LOOP_CODE_RST, LEN_NONE, 1'b0, 8'd0, 8'd0);
        send_frame(scpp_pkg::ADC_CODE_RST, LEN_NONE, 1'b0, 8'd0, 8'h80); // wrong checksum
        send_byte(8'hFF);                                   // not a start byte
        send_byte(scpp_pkg::START_BYTE);
        send_byte(8'h7F);                                   // unknown command
        send_byte(scpp_pkg::START_BYTE);
        send_byte(scpp_pkg::LED_CODE_RST);
        send_byte(8'h80);                                   // length with top bit set
        send_byte(scpp_pkg::START_BYTE);
        send_byte(scpp_pkg::ADC_CODE_RST);
        send_byte(LEN_PARAM);                               // ADC takes no parameter
        send_byte(scpp_pkg::START_BYTE);
        send_byte(scpp_pkg::LED_CODE_RST);
        send_byte(LEN_NONE);                                // LED needs a parameter
        // Parameter byte that is not L, D or T.
        send_frame(scpp_pkg::LED_CODE_RST, LEN_PARAM, 1'b1, 8'h00, 8'd0);

        // Random phases with varied command codes; first and last use the reset codes.
        for (int phase = 0; phase < 7; phase++)
        begin
            settle();
            quiet = (phase == 2);
            case (phase)
                0: ;    // Reset codes; the result side takes its long stall here.
                1:
                begin
                    write_code(scpp_pkg::REG_LED_CODE, 8'h00);
                    write_code(scpp_pkg::REG_LOOP_CODE, 8'hFF);
                    write_code(scpp_pkg::REG_ADC_CODE, scpp_pkg::START_BYTE);
                    write_code(REG_UNUSED, 8'hA5);
                end
                2:
                begin
                    // All three codes equal, so the LED command shadows the others.
                    shared = 8'($urandom_range(0, 255));
                    write_code(scpp_pkg::REG_LED_CODE, shared);
                    write_code(scpp_pkg::REG_LOOP_CODE, shared);
                    write_code(scpp_pkg::REG_ADC_CODE, shared);
                end
                3:
                begin
                    shared = 8'($urandom_range(0, 255));
                    write_code(scpp_pkg::REG_LED_CODE, 8'($urandom_range(0, 255)));
                    write_code(scpp_pkg::REG_LOOP_CODE, shared);
                    write_code(scpp_pkg::REG_ADC_CODE, shared);
                end
                4:
                begin
                    write_code(scpp_pkg::REG_LED_CODE, 8'($urandom_range(0, 255)));
                    write_code(scpp_pkg::REG_LOOP_CODE, 8'($urandom_range(0, 255)));
                    write_code(scpp_pkg::REG_ADC_CODE, 8'($urandom_range(0, 255)));
                end
                5:
                begin
                    write_code(scpp_pkg::REG_LED_CODE, 8'hFF);
                    write_code(scpp_pkg::REG_LOOP_CODE, 8'h00);
                    write_code(scpp_pkg::REG_ADC_CODE, 8'h80);
                end
                default:
                begin
                    write_code(scpp_pkg::REG_LED_CODE, scpp_pkg::LED_CODE_RST);
                    write_code(scpp_pkg::REG_LOOP_CODE, scpp_pkg::LOOP_CODE_RST);
                    write_code(scpp_pkg::REG_ADC_CODE, scpp_pkg::ADC_CODE_RST);
                end
            endcase
            if (phase == 0)
                hold_request = 1'b1;
            start_count = bytes_sent;
            while (bytes_sent - start_count < PHASE_BYTES)
                random_frame();
        end
        settle();

        if (sb.owed_events.size() != 0)
            sb.report($sformatf("%0d events never arrived", sb.owed_events.size()));
        $display("Run covered %0d bytes and %0d event beats over seven command-code sets,",
                 bytes_sent, sb.events_seen);
        $display("including equal and extreme codes, a long result stall and a no-idle stretch.");
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/scpp_pkg.sv
rtl/scpp_fsm.sv
rtl/serial_command_packet_parser_core.sv
tb/tb.sv
